// File: hdl/cnp_pkg.sv
package cnp_pkg;

  localparam int unsigned HDR_LEN = 110;
  localparam int unsigned TRAILER_LEN = 10;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_NAME_PAD,
    PH_DATA,
    PH_DATA_PAD
  } phase_t;

  typedef enum logic [2:0] {
    K_NAME  = 3'd0,
    K_ENTRY = 3'd1,
    K_DATA  = 3'd2,
    K_FIN   = 3'd3,
    K_ERR   = 3'd4
  } kind_t;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_TRAILER   = 3'd0;
  localparam logic [2:0] ST_EXHAUSTED = 3'd1;
  localparam logic [2:0] ST_MAGIC     = 3'd2;
  localparam logic [2:0] ST_HEX       = 3'd3;
  localparam logic [2:0] ST_NAME_END  = 3'd4;
  localparam logic [2:0] ST_NAME_SIZE = 3'd5;
  localparam logic [2:0] ST_DATA_END  = 3'd6;

  localparam logic [0:0] REG_IMAGE_SIZE = 1'b0;

  typedef struct packed {
    logic [31:0] ino;
    logic [31:0] mode;
    logic [31:0] uid;
    logic [31:0] gid;
    logic [31:0] nlink;
    logic [31:0] mtime;
    logic [31:0] file_size;
    logic [31:0] device;
    logic [31:0] name_size;
  } record_t;

  // One queue entry: a result, plus an optional exhausted-finish after it.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_val;
    logic [2:0]  status;
    record_t     rec;
    logic        two;
  } entry_t;

  function automatic logic [7:0] magic_char(input logic [2:0] i);
    unique case (i)
      3'd0: magic_char = 8'h30;
      3'd1: magic_char = 8'h37;
      3'd2: magic_char = 8'h30;
      3'd3: magic_char = 8'h37;
      3'd4: magic_char = 8'h30;
      3'd5: magic_char = 8'h31;
      default: magic_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] i);
    unique case (i)
      4'd0: trailer_char = 8'h54;
      4'd1: trailer_char = 8'h52;
      4'd2: trailer_char = 8'h41;
      4'd3: trailer_char = 8'h49;
      4'd4: trailer_char = 8'h4C;
      4'd5: trailer_char = 8'h45;
      4'd6: trailer_char = 8'h52;
      4'd7, 4'd8, 4'd9: trailer_char = 8'h21;
      default: trailer_char = 8'h00;
    endcase
  endfunction

  // Bit 4 flags a valid digit, bits 3:0 hold its value (zero if invalid).
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_digit = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_digit = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_digit = {1'b1, 4'(c - 8'h37)};
    end else begin
      hex_digit = 5'd0;
    end
  endfunction

endpackage

// File: hdl/cnp_if.sv
interface cnp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       first;
  modport source (output valid, output byte_in, output first, input ready);
  modport sink (input valid, input byte_in, input first, output ready);
endinterface

interface cnp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  byte_out;
  logic [31:0] ino;
  logic [31:0] mode;
  logic [31:0] uid;
  logic [31:0] gid;
  logic [31:0] nlink;
  logic [31:0] mtime;
  logic [31:0] file_size;
  logic [31:0] device;
  logic [31:0] name_size;
  logic [2:0]  status;
  modport source (output valid, output kind, output byte_out, output ino, output mode,
                  output uid, output gid, output nlink, output mtime, output file_size,
                  output device, output name_size, output status, input ready);
  modport sink (input valid, input kind, input byte_out, input ino, input mode,
                input uid, input gid, input nlink, input mtime, input file_size,
                input device, input name_size, input status, output ready);
endinterface

// File: hdl/cpio_newc_stream_parser.sv
// Channel  Dir  Transfer when          Payload
// in_ch    in   valid && ready         byte_in, first
// out_ch   out  valid && ready         kind, byte_out, record fields, status
// apb      in   psel&penable&pwrite    image_size at address 0
//
// One byte per cycle; the parser decides each byte in the cycle it is taken.
// Results wait in a two-entry queue; a byte with an extra finish result gives
// two results on out_ch. Input stalls only while the queue is full.
// rst is synchronous; it clears the parser, the queue and image_size.
module cpio_newc_stream_parser #(
  parameter int unsigned PATH_LIMIT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  cnp_in_if.sink      in_ch,
  cnp_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] image_size;
  logic push, full;
  cnp_pkg::entry_t ent;

  assign pready = 1'b1;
  assign prdata = (paddr == cnp_pkg::REG_IMAGE_SIZE) ? image_size : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= '0;
    end else if (psel && penable && pwrite && paddr == cnp_pkg::REG_IMAGE_SIZE) begin
      image_size <= pwdata;
    end
  end

  assign in_ch.ready = !full;

  cnp_front #(.PATH_LIMIT(PATH_LIMIT)) u_front (
    .clk(clk),
    .rst(rst),
    .acc(in_ch.valid && in_ch.ready),
    .byte_in(in_ch.byte_in),
    .first(in_ch.first),
    .image_size(image_size),
    .push(push),
    .ent(ent)
  );

  cnp_back u_back (
    .clk(clk),
    .rst(rst),
    .push(push),
    .ent(ent),
    .full(full),
    .out_ch(out_ch)
  );

endmodule

// File: hdl/cnp_front.sv
module cnp_front #(
  parameter int unsigned PATH_LIMIT = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  logic [7:0]        byte_in,
  input  logic              first,
  input  logic [31:0]       image_size,
  output logic              push,
  output cnp_pkg::entry_t   ent
);

  localparam int unsigned NW = $clog2(PATH_LIMIT);

  cnp_pkg::phase_t phase, phase_next;
  logic [31:0] position, position_next;
  logic [31:0] count, count_next;
  logic [NW-1:0] name_idx, name_idx_next;
  logic [31:0] field_shift, field_shift_next;
  logic [31:0] h_ino, h_mode, h_uid, h_gid, h_nlink, h_mtime, h_fsize, h_nsize;
  logic [15:0] h_major, h_minor;
  logic [31:0] h_ino_n, h_mode_n, h_uid_n, h_gid_n, h_nlink_n, h_mtime_n, h_fsize_n;
  logic [31:0] h_nsize_n;
  logic [15:0] h_major_n, h_minor_n;
  logic magic_bad, magic_bad_next, hex_bad, hex_bad_next;
  logic trailer_match, trailer_match_next;
  logic stopped, stopped_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cnp_pkg::PH_HEADER;
      position <= '0;
      count <= '0;
      name_idx <= '0;
      field_shift <= '0;
      magic_bad <= 1'b0;
      hex_bad <= 1'b0;
      trailer_match <= 1'b1;
      stopped <= 1'b0;
    end else begin
      phase <= phase_next;
      position <= position_next;
      count <= count_next;
      name_idx <= name_idx_next;
      field_shift <= field_shift_next;
      magic_bad <= magic_bad_next;
      hex_bad <= hex_bad_next;
      trailer_match <= trailer_match_next;
      stopped <= stopped_next;
    end
    h_ino <= h_ino_n;
    h_mode <= h_mode_n;
    h_uid <= h_uid_n;
    h_gid <= h_gid_n;
    h_nlink <= h_nlink_n;
    h_mtime <= h_mtime_n;
    h_fsize <= h_fsize_n;
    h_nsize <= h_nsize_n;
    h_major <= h_major_n;
    h_minor <= h_minor_n;
  end

  cnp_pkg::phase_t e_phase;
  logic [31:0] e_pos, e_count, e_shift;
  logic [NW-1:0] e_nidx;
  logic e_mb, e_hb, e_tm, e_stop;
  logic [32:0] nxt, h_align;
  logic [33:0] ds_end;
  logic [6:0] hidx, rel;
  logic [3:0] fld;
  logic [4:0] hd;
  logic [31:0] shifted, last;
  logic end_fin, last_pad;

  always_comb begin
    // restart on a first byte
    e_phase = first ? cnp_pkg::PH_HEADER : phase;
    e_pos   = first ? '0 : position;
    e_count = first ? '0 : count;
    e_nidx  = first ? '0 : name_idx;
    e_shift = first ? '0 : field_shift;
    e_mb    = first ? 1'b0 : magic_bad;
    e_hb    = first ? 1'b0 : hex_bad;
    e_tm    = first ? 1'b1 : trailer_match;
    e_stop  = first ? 1'b0 : stopped;

    nxt = {1'b0, e_pos} + 33'd1;
    h_align = (nxt + 33'd3) & ~33'd3;
    ds_end = {1'b0, h_align} + {2'b0, h_fsize};
    end_fin = ({1'b0, h_align} + 34'(cnp_pkg::HDR_LEN)) > {2'b0, image_size};
    last_pad = (h_align != nxt);
    hidx = e_count[6:0];
    rel = hidx - 7'd6;
    fld = rel[6:3];
    hd = cnp_pkg::hex_digit(byte_in);
    shifted = {e_shift[27:0], hd[3:0]};
    last = h_nsize - 32'd1;

    phase_next = phase;
    position_next = position;
    count_next = count;
    name_idx_next = name_idx;
    field_shift_next = field_shift;
    magic_bad_next = magic_bad;
    hex_bad_next = hex_bad;
    trailer_match_next = trailer_match;
    stopped_next = stopped;
    h_ino_n = h_ino;
    h_mode_n = h_mode;
    h_uid_n = h_uid;
    h_gid_n = h_gid;
    h_nlink_n = h_nlink;
    h_mtime_n = h_mtime;
    h_fsize_n = h_fsize;
    h_nsize_n = h_nsize;
    h_major_n = h_major;
    h_minor_n = h_minor;
    push = 1'b0;
    ent = '0;

    if (acc && !e_stop) begin
      phase_next = e_phase;
      count_next = e_count;
      name_idx_next = e_nidx;
      field_shift_next = e_shift;
      magic_bad_next = e_mb;
      hex_bad_next = e_hb;
      trailer_match_next = e_tm;
      stopped_next = 1'b0;
      position_next = nxt[31:0];
      unique case (e_phase)
        cnp_pkg::PH_HEADER: begin
          if (hidx == 7'd0 && ({1'b0, e_pos} + 33'(cnp_pkg::HDR_LEN)) > {1'b0, image_size})
          begin
            push = 1'b1;
            ent.kind = cnp_pkg::K_FIN;
            ent.status = cnp_pkg::ST_EXHAUSTED;
            stopped_next = 1'b1;
          end else begin
            if (hidx < 7'd6) begin
              if (byte_in != cnp_pkg::magic_char(hidx[2:0])) magic_bad_next = 1'b1;
            end else begin
              if (!hd[4] && (fld <= 4'd6 || (fld >= 4'd9 && fld <= 4'd11)))
                hex_bad_next = 1'b1;
              field_shift_next = shifted;
              if (rel[2:0] == 3'd7) begin
                unique case (fld)
                  4'd0: h_ino_n = shifted;
                  4'd1: h_mode_n = shifted;
                  4'd2: h_uid_n = shifted;
                  4'd3: h_gid_n = shifted;
                  4'd4: h_nlink_n = shifted;
                  4'd5: h_mtime_n = shifted;
                  4'd6: h_fsize_n = shifted;
                  4'd9: h_major_n = shifted[15:0];
                  4'd10: h_minor_n = shifted[15:0];
                  4'd11: h_nsize_n = shifted;
                  default: ;
                endcase
              end
            end
            count_next = e_count + 32'd1;
            if (hidx >= 7'(cnp_pkg::HDR_LEN - 1)) begin
              ent.kind = cnp_pkg::K_ERR;
              push = 1'b1;
              if (magic_bad_next) ent.status = cnp_pkg::ST_MAGIC;
              else if (hex_bad_next) ent.status = cnp_pkg::ST_HEX;
              else if ((nxt + {1'b0, h_nsize}) > {1'b0, image_size})
                ent.status = cnp_pkg::ST_NAME_END;
              else if (h_nsize == 32'd0 || h_nsize >= 32'(PATH_LIMIT))
                ent.status = cnp_pkg::ST_NAME_SIZE;
              else push = 1'b0;
              if (push) begin
                stopped_next = 1'b1;
              end else begin
                ent = '0;
                phase_next = cnp_pkg::PH_NAME;
                count_next = '0;
                name_idx_next = '0;
                trailer_match_next = 1'b1;
              end
            end
          end
        end
        cnp_pkg::PH_NAME: begin
          push = 1'b1;
          if ({{(32-NW){1'b0}}, e_nidx} < last) begin
            ent.kind = cnp_pkg::K_NAME;
            ent.byte_val = byte_in;
            if (e_nidx < NW'(cnp_pkg::TRAILER_LEN)) begin
              if (byte_in != cnp_pkg::trailer_char(e_nidx[3:0])) trailer_match_next = 1'b0;
            end else if (e_nidx == NW'(cnp_pkg::TRAILER_LEN) && byte_in != 8'd0) begin
              trailer_match_next = 1'b0;
            end
            name_idx_next = e_nidx + 1'b1;
          end else if (e_tm && last >= 32'(cnp_pkg::TRAILER_LEN)) begin
            ent.kind = cnp_pkg::K_FIN;
            ent.status = cnp_pkg::ST_TRAILER;
            stopped_next = 1'b1;
          end else if (ds_end > {2'b0, image_size}) begin
            ent.kind = cnp_pkg::K_ERR;
            ent.status = cnp_pkg::ST_DATA_END;
            stopped_next = 1'b1;
          end else begin
            ent.kind = cnp_pkg::K_ENTRY;
            ent.rec = '{ino: h_ino, mode: h_mode, uid: h_uid, gid: h_gid, nlink: h_nlink,
                        mtime: h_mtime, file_size: h_fsize,
                        device: {h_major, h_minor}, name_size: h_nsize};
            count_next = '0;
            if (last_pad) begin
              phase_next = cnp_pkg::PH_NAME_PAD;
            end else if (h_fsize != 32'd0) begin
              phase_next = cnp_pkg::PH_DATA;
            end else if (end_fin) begin
              ent.two = 1'b1;
              stopped_next = 1'b1;
            end else begin
              phase_next = cnp_pkg::PH_HEADER;
            end
          end
        end
        cnp_pkg::PH_NAME_PAD: begin
          if (nxt[1:0] == 2'd0) begin
            count_next = '0;
            if (h_fsize != 32'd0) begin
              phase_next = cnp_pkg::PH_DATA;
            end else if (end_fin) begin
              push = 1'b1;
              ent.kind = cnp_pkg::K_FIN;
              ent.status = cnp_pkg::ST_EXHAUSTED;
              stopped_next = 1'b1;
            end else begin
              phase_next = last_pad ? cnp_pkg::PH_DATA_PAD : cnp_pkg::PH_HEADER;
            end
          end
        end
        cnp_pkg::PH_DATA: begin
          push = 1'b1;
          ent.kind = cnp_pkg::K_DATA;
          ent.byte_val = byte_in;
          count_next = e_count + 32'd1;
          if (count_next >= h_fsize) begin
            if (end_fin) begin
              ent.two = 1'b1;
              stopped_next = 1'b1;
            end else begin
              phase_next = last_pad ? cnp_pkg::PH_DATA_PAD : cnp_pkg::PH_HEADER;
              count_next = '0;
            end
          end
        end
        cnp_pkg::PH_DATA_PAD: begin
          if (nxt[1:0] == 2'd0) begin
            phase_next = cnp_pkg::PH_HEADER;
            count_next = '0;
          end
        end
        default: begin
          phase_next = cnp_pkg::PH_HEADER;
          count_next = '0;
        end
      endcase
    end else if (acc) begin
      // stopped: hold state, drop the byte
      stopped_next = 1'b1;
    end
  end

  a_push_needs_acc: assert property (@(posedge clk) disable iff (rst) push |-> acc)
    else $error("result pushed without a transfer");
  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    (stopped && !(acc && first)) |=> stopped)
    else $error("parser left the stopped state without a restart");
  a_two_is_final: assert property (@(posedge clk) disable iff (rst)
    (push && ent.two) |-> stopped_next)
    else $error("exhausted finish without stopping");

endmodule

// File: hdl/cnp_back.sv
module cnp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cnp_pkg::entry_t ent,
  output logic            full,
  cnp_out_if.source       out_ch
);

  cnp_pkg::entry_t q [2];
  logic [1:0] cnt;
  logic head, tail, sub;
  logic pop, take;
  cnp_pkg::entry_t cur;

  assign full = (cnt == 2'd2);
  assign cur = q[head];
  assign take = out_ch.valid && out_ch.ready;
  assign pop = take && (sub || !cur.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      head <= 1'b0;
      tail <= 1'b0;
      sub <= 1'b0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
      if (push) tail <= ~tail;
      if (pop) head <= ~head;
      if (take) sub <= !sub && cur.two;
    end
    if (push) q[tail] <= ent;
  end

  always_comb begin
    out_ch.valid = (cnt != 2'd0);
    if (sub) begin
      out_ch.kind = cnp_pkg::K_FIN;
      out_ch.byte_out = '0;
      out_ch.status = cnp_pkg::ST_EXHAUSTED;
      {out_ch.ino, out_ch.mode, out_ch.uid, out_ch.gid, out_ch.nlink, out_ch.mtime,
       out_ch.file_size, out_ch.device, out_ch.name_size} = '0;
    end else begin
      out_ch.kind = cur.kind;
      out_ch.byte_out = cur.byte_val;
      out_ch.status = cur.status;
      {out_ch.ino, out_ch.mode, out_ch.uid, out_ch.gid, out_ch.nlink, out_ch.mtime,
       out_ch.file_size, out_ch.device, out_ch.name_size} = cur.rec;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count out of range");
  a_sub_valid: assert property (@(posedge clk) disable iff (rst)
    sub |-> (out_ch.valid && cur.two))
    else $error("second result without a pending entry");

endmodule

// File: tb/sv/cpio_newc_stream_parser_tb.sv
module cpio_newc_stream_parser_tb;

  localparam logic [47:0] MAGIC_TXT = "070701";
  localparam logic [79:0] TRAILER_TXT = "TRAILER!!!";
  localparam int unsigned NAME_LIMIT = 4096;
  localparam int unsigned HOLD_CYCLES = 80;

  typedef enum int {IMG_CLEAN, IMG_MAGIC, IMG_HEX, IMG_NSIZE, IMG_TRUNC} img_mode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  b;
    logic [31:0] ino;
    logic [31:0] mode;
    logic [31:0] uid;
    logic [31:0] gid;
    logic [31:0] nlink;
    logic [31:0] mtime;
    logic [31:0] fsize;
    logic [31:0] device;
    logic [31:0] nsize;
    logic [2:0]  status;
  } parse_res_t;

  typedef struct {
    bit              do_cfg;
    logic [31:0]     cfg_val;
    logic [7:0]      b;
    logic            f;
    bit              typed;
    bit              has_res;
    cnp_pkg::kind_t  kind;
    logic [2:0]      status;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0] paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  cnp_in_if in_ch();
  cnp_out_if out_ch();

  cpio_newc_stream_parser i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 1000000);
    $display("RESULT: ERROR");
    $finish;
  end

  // parser shadow state
  logic [31:0]      m_img_size;
  logic [31:0]      m_pos, m_cnt, m_shift;
  cnp_pkg::phase_t  m_phase;
  logic [31:0]      m_held [13];
  bit               m_magic_bad, m_hex_bad, m_trl_match, m_stopped;
  bit               quiet;

  parse_res_t  expected_q[$];
  int          fails = 0;
  int          snd_idle = 0, rcv_idle = 0;
  int          hold_asked = 0, hold_done = 0, hold_left = 0;
  logic [7:0]  image_q[$];
  dir_row_t    rows[$];

  function automatic void restart_parse();
    m_pos = '0; m_phase = cnp_pkg::PH_HEADER; m_cnt = '0; m_shift = '0;
    foreach (m_held[i]) m_held[i] = '0;
    m_magic_bad = 0; m_hex_bad = 0; m_trl_match = 1; m_stopped = 0;
  endfunction

  function automatic void emit(cnp_pkg::kind_t k, logic [7:0] b, logic [2:0] st, bit rec);
    parse_res_t r;
    r = '0;
    r.kind = k; r.b = b; r.status = st;
    if (rec) begin
      r.ino = m_held[0]; r.mode = m_held[1]; r.uid = m_held[2]; r.gid = m_held[3];
      r.nlink = m_held[4]; r.mtime = m_held[5]; r.fsize = m_held[6];
      r.device = {m_held[9][15:0], m_held[10][15:0]};
      r.nsize = m_held[11];
    end
    if (!quiet) expected_q.push_back(r);
  endfunction

  function automatic logic [33:0] align4(logic [33:0] v);
    return (v + 34'd3) & ~34'd3;
  endfunction

  function automatic void close_entry(logic [33:0] nxt);
    logic [33:0] h;
    h = align4(nxt);
    if (h + 34'd110 > {2'b0, m_img_size}) begin
      emit(cnp_pkg::K_FIN, 8'h00, cnp_pkg::ST_EXHAUSTED, 0);
      m_stopped = 1;
    end else begin
      m_phase = (h != nxt) ? cnp_pkg::PH_DATA_PAD : cnp_pkg::PH_HEADER;
      m_cnt = '0;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic f);
    logic [33:0] pos, nxt, ds;
    logic [31:0] idx, rel, fld, last;
    logic [3:0]  nib;
    bit          ok;
    logic [2:0]  st;
    if (f) restart_parse();
    if (m_stopped) return;
    pos = {2'b0, m_pos};
    nxt = pos + 34'd1;
    idx = m_cnt;
    case (m_phase)
      cnp_pkg::PH_HEADER: begin
        if (idx == 0 && pos + 34'd110 > {2'b0, m_img_size}) begin
          emit(cnp_pkg::K_FIN, 8'h00, cnp_pkg::ST_EXHAUSTED, 0);
          m_stopped = 1;
          return;
        end
        if (idx < 6) begin
          if (b != MAGIC_TXT[47 - 8 * idx -: 8]) m_magic_bad = 1;
        end else begin
          rel = idx - 6;
          fld = rel >> 3;
          ok = 1;
          if (b >= "0" && b <= "9") nib = 4'(b - "0");
          else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 10);
          else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 10);
          else begin
            nib = 4'd0;
            ok = 0;
          end
          if (!ok && (fld <= 6 || (fld >= 9 && fld <= 11))) m_hex_bad = 1;
          m_shift = {m_shift[27:0], nib};
          if (rel[2:0] == 3'd7 && fld != 7 && fld != 8 && fld != 12) m_held[fld] = m_shift;
        end
        m_cnt = idx + 1;
        if (idx >= cnp_pkg::HDR_LEN - 1) begin
          st = cnp_pkg::ST_NONE;
          if (m_magic_bad) st = cnp_pkg::ST_MAGIC;
          else if (m_hex_bad) st = cnp_pkg::ST_HEX;
          else if (nxt + {2'b0, m_held[11]} > {2'b0, m_img_size}) st = cnp_pkg::ST_NAME_END;
          else if (m_held[11] == 0 || m_held[11] >= NAME_LIMIT) st = cnp_pkg::ST_NAME_SIZE;
          if (st != cnp_pkg::ST_NONE) begin
            emit(cnp_pkg::K_ERR, 8'h00, st, 0);
            m_stopped = 1;
            return;
          end
          m_phase = cnp_pkg::PH_NAME; m_cnt = '0; m_trl_match = 1;
        end
      end
      cnp_pkg::PH_NAME: begin
        last = m_held[11] - 1;
        if (idx < last) begin
          emit(cnp_pkg::K_NAME, b, cnp_pkg::ST_NONE, 0);
          if (idx < cnp_pkg::TRAILER_LEN) begin
            if (b != TRAILER_TXT[79 - 8 * idx -: 8]) m_trl_match = 0;
          end else if (idx == cnp_pkg::TRAILER_LEN && b != 0) begin
            m_trl_match = 0;
          end
          m_cnt = idx + 1;
        end else begin
          if (m_trl_match && last >= cnp_pkg::TRAILER_LEN) begin
            emit(cnp_pkg::K_FIN, 8'h00, cnp_pkg::ST_TRAILER, 0);
            m_stopped = 1;
            return;
          end
          ds = align4(nxt);
          if (ds + {2'b0, m_held[6]} > {2'b0, m_img_size}) begin
            emit(cnp_pkg::K_ERR, 8'h00, cnp_pkg::ST_DATA_END, 0);
            m_stopped = 1;
            return;
          end
          emit(cnp_pkg::K_ENTRY, 8'h00, cnp_pkg::ST_NONE, 1);
          m_cnt = '0;
          if (ds != nxt) m_phase = cnp_pkg::PH_NAME_PAD;
          else if (m_held[6] > 0) m_phase = cnp_pkg::PH_DATA;
          else close_entry(nxt);
        end
      end
      cnp_pkg::PH_NAME_PAD: begin
        if (nxt[1:0] == 2'b00) begin
          m_cnt = '0;
          if (m_held[6] > 0) m_phase = cnp_pkg::PH_DATA;
          else close_entry(nxt);
        end
      end
      cnp_pkg::PH_DATA: begin
        emit(cnp_pkg::K_DATA, b, cnp_pkg::ST_NONE, 0);
        m_cnt = m_cnt + 1;
        if (m_cnt >= m_held[6]) close_entry(nxt);
      end
      cnp_pkg::PH_DATA_PAD: begin
        if (nxt[1:0] == 2'b00) begin
          m_phase = cnp_pkg::PH_HEADER;
          m_cnt = '0;
        end
      end
      default: begin
        m_phase = cnp_pkg::PH_HEADER;
        m_cnt = '0;
      end
    endcase
    m_pos = nxt[31:0];
  endfunction

  // output checker
  always @(posedge clk) begin
    parse_res_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.kind, out_ch.byte_out, out_ch.ino, out_ch.mode, out_ch.uid, out_ch.gid,
             out_ch.nlink, out_ch.mtime, out_ch.file_size, out_ch.device, out_ch.name_size,
             out_ch.status};
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_done) begin
      hold_done <= hold_done + 1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic f);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.byte_in <= b;
    in_ch.first <= f;
    do @(posedge clk); while (!in_ch.ready);
    parse_byte(b, f);
    @(negedge clk);
  endtask

  task automatic drain_and_write(input logic [31:0] v);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= cnp_pkg::REG_IMAGE_SIZE; pwdata <= v;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    m_img_size = v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return 8'("0" + n);
    return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n - 10);
  endfunction

  function automatic void push_header(logic [31:0] fv [13], bit junk);
    for (int i = 0; i < 6; i++) image_q.push_back(MAGIC_TXT[47 - 8 * i -: 8]);
    for (int fi = 0; fi < 13; fi++)
      for (int d = 7; d >= 0; d--)
        if (junk && (fi == 7 || fi == 8 || fi == 12)) image_q.push_back(8'($urandom));
        else image_q.push_back(hex_char(fv[fi][4 * d +: 4]));
  endfunction

  function automatic void pad4();
    while (image_q.size() % 4 != 0) image_q.push_back(8'($urandom));
  endfunction

  // Build one archive; return the image size to program.
  function automatic logic [31:0] build_image(img_mode_t md);
    logic [31:0] fv [13];
    int n_ent, bad, hs, pick, d;
    logic [7:0] c;
    image_q.delete();
    n_ent = $urandom_range(0, 1);
    bad = $urandom_range(0, n_ent);
    for (int e = 0; e <= n_ent; e++) begin
      foreach (fv[i]) fv[i] = $urandom;
      fv[6] = (e == n_ent) ? 0 : $urandom_range(0, 10);
      fv[11] = (e == n_ent) ? ($urandom_range(0, 3) ? 11 : 12) : $urandom_range(1, 9);
      if (md == IMG_NSIZE && e == bad) begin
        pick = $urandom_range(0, 3);
        fv[11] = (pick == 0) ? 0 : (pick == 1) ? NAME_LIMIT :
                 (pick == 2) ? 32'hFFFF_FFFF : $urandom_range(NAME_LIMIT, 20000);
      end
      hs = image_q.size();
      push_header(fv, $urandom_range(0, 3) == 0);
      if (md == IMG_MAGIC && e == bad) begin
        pick = $urandom_range(0, 5);
        image_q[hs + pick] = image_q[hs + pick] ^ 8'($urandom_range(1, 255));
      end
      if (md == IMG_HEX && e == bad) begin
        pick = $urandom_range(0, 9);
        pick = (pick <= 6) ? pick : pick + 2;
        d = $urandom_range(0, 7);
        do c = 8'($urandom); while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                                    (c >= "A" && c <= "F"));
        image_q[hs + 6 + 8 * pick + d] = c;
      end
      if (md == IMG_NSIZE && e == bad) begin
        repeat ($urandom_range(1, 6)) image_q.push_back(8'($urandom));
        break;
      end
      if (e == n_ent) begin
        for (int i = 0; i < 10; i++) image_q.push_back(TRAILER_TXT[79 - 8 * i -: 8]);
        image_q.push_back(8'h00);
        if (fv[11] == 12) image_q.push_back(8'($urandom));
      end else begin
        for (int i = 0; i < fv[11]; i++) image_q.push_back(8'($urandom));
      end
      pad4();
      for (int i = 0; i < fv[6]; i++) image_q.push_back(8'($urandom));
      pad4();
    end
    case (md)
      IMG_TRUNC: return $urandom_range(0, image_q.size() - 1);
      IMG_CLEAN: return image_q.size() + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 300));
      default:   return $urandom_range(0, 1) ? 32'hFFFF_FFFF : image_q.size();
    endcase
  endfunction

  function automatic void add_row(bit do_cfg, logic [31:0] v, logic [7:0] b, logic f,
                                  bit typed, bit has_res, cnp_pkg::kind_t k,
                                  logic [2:0] st);
    dir_row_t r;
    r.do_cfg = do_cfg; r.cfg_val = v; r.b = b; r.f = f;
    r.typed = typed; r.has_res = has_res; r.kind = k; r.status = st;
    rows.push_back(r);
  endfunction

  initial begin
    parse_res_t typed_res;
    logic [31:0] isz;
    int sent, k;
    img_mode_t md;
    in_ch.valid = 1'b0;
    in_ch.byte_in = '0;
    in_ch.first = 1'b0;
    m_img_size = '0;
    quiet = 0;
    restart_parse();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // stream without first after reset, zero image, stopped bytes, tight sizes
    add_row(0, 0, 8'h00, 1'b0, 1, 1, cnp_pkg::K_FIN, cnp_pkg::ST_EXHAUSTED);
    add_row(0, 0, 8'hFF, 1'b0, 1, 0, cnp_pkg::K_FIN, cnp_pkg::ST_NONE);
    add_row(0, 0, 8'h30, 1'b1, 1, 1, cnp_pkg::K_FIN, cnp_pkg::ST_EXHAUSTED);
    add_row(1, 32'hFFFF_FFFF, 8'h30, 1'b1, 1, 0, cnp_pkg::K_FIN, cnp_pkg::ST_NONE);
    add_row(0, 0, 8'hAA, 1'b0, 1, 0, cnp_pkg::K_FIN, cnp_pkg::ST_NONE);
    add_row(0, 0, 8'h55, 1'b0, 0, 0, cnp_pkg::K_FIN, cnp_pkg::ST_NONE);
    add_row(1, 109, 8'h30, 1'b1, 1, 1, cnp_pkg::K_FIN, cnp_pkg::ST_EXHAUSTED);
    add_row(1, 110, 8'h30, 1'b1, 0, 0, cnp_pkg::K_FIN, cnp_pkg::ST_NONE);
    add_row(0, 0, 8'h37, 1'b0, 0, 0, cnp_pkg::K_FIN, cnp_pkg::ST_NONE);
    add_row(0, 0, 8'hFF, 1'b1, 0, 0, cnp_pkg::K_FIN, cnp_pkg::ST_NONE);
    foreach (rows[i]) begin
      if (rows[i].do_cfg) drain_and_write(rows[i].cfg_val);
      quiet = rows[i].typed;
      if (rows[i].typed && rows[i].has_res) begin
        typed_res = '0;
        typed_res.kind = rows[i].kind;
        typed_res.status = rows[i].status;
        expected_q.push_back(typed_res);
      end
      send_byte(rows[i].b, rows[i].f);
      quiet = 0;
    end

    sent = 0;
    k = 0;
    while (sent < 800 || k < 5) begin
      if (sent < 270) begin
        snd_idle = 21; rcv_idle = 50;
      end else if (sent < 540) begin
        snd_idle = 50; rcv_idle = 21;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      if (k < 5) md = img_mode_t'(k);
      else begin
        isz = $urandom_range(0, 9);
        md = (isz < 6) ? IMG_CLEAN : img_mode_t'(isz - 5);
      end
      isz = build_image(md);
      drain_and_write(isz);
      // long hold-off so the result queue fills and the input stalls
      if (k == 2) hold_asked++;
      foreach (image_q[i]) send_byte(image_q[i], i == 0);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
      sent += image_q.size();
      k++;
    end

    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/cnp_pkg.sv
hdl/cnp_if.sv
hdl/cnp_front.sv
hdl/cnp_back.sv
hdl/cpio_newc_stream_parser.sv
tb/sv/cpio_newc_stream_parser_tb.sv
